// File: sv/fsrq_pkg.sv
// ----------------------------------------------------------------------------
// fsrq_pkg
// Shared types and constants of the fair-share run queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fsrq_pkg;

    localparam int VR_W     = 63;
    localparam int GRAN_W   = 30;
    localparam int LAT_W    = 32;
    localparam int DELTA_W  = 32;
    localparam int RAN_W    = 64;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 32;

    localparam logic [VR_W-1:0] VR_MAX = {VR_W{1'b1}};

    localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(1000000);
    localparam logic [LAT_W-1:0]  LAT_RESET  = LAT_W'(10000000);

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 3'd0,
        OP_PICK    = 3'd1,
        OP_TICK    = 3'd2,
        OP_BLOCK   = 3'd3,
        OP_YIELD   = 3'd4,
        OP_DONE    = 3'd5,
        OP_CHARGE  = 3'd6,
        OP_BOOST   = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE   = 3'd0,
        STAT_PICKED = 3'd1,
        STAT_KEPT   = 3'd2,
        STAT_IDLE   = 3'd3,
        STAT_FULL   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TS_BLOCKED  = 2'd0,
        TS_RUNNABLE = 2'd1,
        TS_RUNNING  = 2'd2,
        TS_DONE     = 2'd3
    } t_task_state;

    localparam logic CFG_IDX_GRAN = 1'b0;
    localparam logic CFG_IDX_LAT  = 1'b1;

endpackage

`default_nettype wire

// File: sv/fair_share_run_queue.sv
// ----------------------------------------------------------------------------
// fair_share_run_queue
// Per-cpu fair-share run queue with a scanned slot memory and slice check.
// ----------------------------------------------------------------------------
// Usage:
//   one operation beat enters on i_valid/o_ready; exactly one result beat
//   leaves on o_valid/i_ready for each. o_ready is high only while the
//   sequencer is idle, one operation is worked on at a time.
//   enqueue, pick (unless the current task is kept), done (unless it names
//   the current task) and boost release (with a current task) sweep the
//   slot memory once through its single read port, one slot a cycle.
//   tick with a task runs the restoring divider, one quotient bit a cycle,
//   unless the minimum slice wins. block, yield and charge skip both.
//   the result sits in an output register, so the next operation is taken
//   while it waits; a finished operation holds until that register is free.
//   reset (synchronous, active low) empties the queue at once through the
//   per-slot valid bits, clears the current task and floor, and restores the
//   default slice settings. configuration writes take effect immediately and
//   are meant to land only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fair_share_run_queue
    import fsrq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 64,
    parameter int TASK_ID_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_index,
    input  wire logic [CFG_W-1:0]                   i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [OP_W-1:0]                    i_opcode,
    input  wire logic [TASK_ID_WIDTH-1:0]           i_task_id,
    input  wire logic [VR_W-1:0]                    i_task_vruntime,
    input  wire logic [DELTA_W-1:0]                 i_runtime_delta_ns,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [STATUS_W-1:0]                     o_status,
    output logic                                    o_task_valid,
    output logic [TASK_ID_WIDTH-1:0]                o_current_id,
    output logic [VR_W-1:0]                         o_current_vruntime,
    output logic                                    o_released_valid,
    output logic [TASK_ID_WIDTH-1:0]                o_released_id,
    output logic [VR_W-1:0]                         o_released_vruntime,
    output logic [VR_W-1:0]                         o_floor_vruntime,
    output logic                                    o_preempt_pending,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]        o_queued_count
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int TKW  = $clog2(QUEUE_DEPTH + 2);
    localparam int NUMW = LAT_W + 1;
    localparam int PRW  = GRAN_W + TKW;
    localparam int MW   = TASK_ID_WIDTH + VR_W;
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MUL, S_DIV, S_FIN, S_PUSH
    } t_state;

    t_state                   r_state;
    t_op                      r_op;
    logic [TASK_ID_WIDTH-1:0] r_id;
    logic [TASK_ID_WIDTH-1:0] r_ins_id;
    logic [VR_W-1:0]          r_ins_vr;
    logic                     r_insert;

    logic [GRAN_W-1:0]        r_gran;
    logic [LAT_W-1:0]         r_lat;

    logic [QUEUE_DEPTH-1:0]   r_slot_valid;
    logic [CNTW-1:0]          r_count;
    logic                     r_cur_valid;
    logic [TASK_ID_WIDTH-1:0] r_cur_task;
    t_task_state              r_cur_state;
    logic [VR_W-1:0]          r_cur_vr;
    logic [RAN_W-1:0]         r_ran;
    logic [VR_W-1:0]          r_floor;
    logic                     r_preempt;

    logic [AW-1:0]            r_addr;
    logic [AW-1:0]            r_pidx;
    logic                     r_issuing;
    logic                     r_pend;
    logic                     r_have;
    logic [VR_W-1:0]          r_min;
    logic [AW-1:0]            r_best;
    logic [TASK_ID_WIDTH-1:0] r_best_task;
    logic                     r_free_found;
    logic [AW-1:0]            r_free_idx;

    logic [PRW-1:0]           r_prod;
    logic [NUMW-1:0]          r_slice;

    t_status                  r_status;
    logic                     r_rel_valid;
    logic [TASK_ID_WIDTH-1:0] r_rel_id;
    logic [VR_W-1:0]          r_rel_vr;

    logic [MW-1:0]            rd_data;
    logic [TASK_ID_WIDTH-1:0] rd_task;
    logic [VR_W-1:0]          rd_vr;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [MW-1:0]            ram_wdata;

    logic                     div_start;
    logic                     div_done;
    logic [NUMW-1:0]          div_quo;
    logic [TKW-1:0]           n_tasks;
    logic [NUMW-1:0]          n_num;

    logic                     n_contend;
    logic                     n_ins_ok;
    logic                     n_fl_have;
    logic [VR_W-1:0]          n_fl_min;
    logic                     n_keep_prev;
    logic [VR_W-1:0]          n_new_floor;
    logic [VR_W:0]            n_vr_sum;
    logic [RAN_W:0]           n_ran_sum;
    logic                     accept;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign rd_task   = rd_data[MW-1:VR_W];
    assign rd_vr     = rd_data[VR_W-1:0];
    assign n_contend = r_cur_valid &&
                       (r_cur_state == TS_RUNNABLE || r_cur_state == TS_RUNNING);
    assign n_ins_ok  = r_insert && r_free_found;
    assign n_tasks   = TKW'(r_count) + TKW'(1);
    assign n_num     = NUMW'(r_lat) + NUMW'(n_tasks) - NUMW'(1);
    assign n_vr_sum  = {1'b0, r_cur_vr} + (VR_W+1)'(i_runtime_delta_ns);
    assign n_ran_sum = {1'b0, r_ran} + (RAN_W+1)'(i_runtime_delta_ns);
    assign div_start = (r_state == S_MUL) && !(r_prod > PRW'(r_lat));
    assign n_keep_prev = n_contend && (!r_have || r_cur_vr < r_min);

    // floor candidate after the sweep
    always_comb begin
        n_fl_have = r_have;
        n_fl_min  = r_min;
        if ((r_op == OP_ENQUEUE || r_op == OP_DONE) && n_contend &&
            (!n_fl_have || r_cur_vr < n_fl_min)) begin
            n_fl_have = 1'b1;
            n_fl_min  = r_cur_vr;
        end
        if ((r_op == OP_ENQUEUE || r_op == OP_BOOST) && n_ins_ok &&
            (!n_fl_have || r_ins_vr < n_fl_min)) begin
            n_fl_have = 1'b1;
            n_fl_min  = r_ins_vr;
        end
        if (r_op == OP_PICK) begin
            n_fl_have = r_have || n_contend;
            n_fl_min  = n_keep_prev ? r_cur_vr : r_min;
        end
        n_new_floor = (n_fl_have && n_fl_min > r_floor) ? n_fl_min : r_floor;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_free_idx;
        ram_wdata = {r_ins_id, r_ins_vr};
        if (r_state == S_FIN) begin
            if ((r_op == OP_ENQUEUE || r_op == OP_BOOST) && n_ins_ok) begin
                ram_we = 1'b1;
            end else if (r_op == OP_PICK && n_contend && !n_keep_prev) begin
                ram_we    = 1'b1;
                ram_waddr = r_best;
                ram_wdata = {r_cur_task, r_cur_vr};
            end
        end
    end

    fsrq_ram #(
        .WIDTH (MW),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_SCAN && r_issuing),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    fsrq_div #(
        .NW (NUMW),
        .DW (TKW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_num),
        .i_den   (n_tasks),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gran       <= GRAN_RESET;
            r_lat        <= LAT_RESET;
            r_slot_valid <= '0;
            r_count      <= '0;
            r_cur_valid  <= 1'b0;
            r_cur_task   <= '0;
            r_cur_state  <= TS_BLOCKED;
            r_cur_vr     <= '0;
            r_ran        <= '0;
            r_floor      <= '0;
            r_preempt    <= 1'b0;
            r_issuing    <= 1'b0;
            r_pend       <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_GRAN) begin
                    r_gran <= i_cfg_data[GRAN_W-1:0];
                end else begin
                    r_lat <= i_cfg_data[LAT_W-1:0];
                end
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op         <= t_op'(i_opcode);
                        r_id         <= i_task_id;
                        r_status     <= STAT_DONE;
                        r_rel_valid  <= 1'b0;
                        r_rel_id     <= '0;
                        r_rel_vr     <= '0;
                        r_insert     <= 1'b0;
                        r_have       <= 1'b0;
                        r_free_found <= 1'b0;
                        r_addr       <= '0;
                        r_issuing    <= 1'b1;
                        r_pend       <= 1'b0;
                        r_ins_id     <= i_task_id;
                        r_ins_vr     <= (i_task_vruntime > r_floor) ?
                                        i_task_vruntime : r_floor;
                        r_prod       <= PRW'(n_tasks) * PRW'(r_gran);
                        r_state      <= S_PUSH;
                        unique case (t_op'(i_opcode))
                            OP_ENQUEUE: begin
                                r_state <= S_SCAN;
                                if (r_cur_valid && r_cur_task == i_task_id) begin
                                    if (r_cur_state != TS_DONE) begin
                                        r_cur_state <= TS_RUNNABLE;
                                    end
                                end else begin
                                    r_insert <= 1'b1;
                                end
                            end
                            OP_PICK: begin
                                if (r_cur_valid && r_cur_state == TS_RUNNING &&
                                    !r_preempt) begin
                                    r_status <= STAT_KEPT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_TICK: begin
                                if (r_cur_valid) begin
                                    r_state <= S_MUL;
                                end
                            end
                            OP_BLOCK: begin
                                if (r_cur_valid && r_cur_state != TS_DONE) begin
                                    r_cur_state <= TS_BLOCKED;
                                end
                            end
                            OP_YIELD: begin
                                if (r_cur_valid && r_cur_state != TS_DONE) begin
                                    r_cur_state <= TS_RUNNABLE;
                                end
                            end
                            OP_DONE: begin
                                if (r_cur_valid && r_cur_task == i_task_id) begin
                                    r_cur_state <= TS_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_CHARGE: begin
                                if (r_cur_valid) begin
                                    r_cur_vr <= n_vr_sum[VR_W] ? VR_MAX :
                                                n_vr_sum[VR_W-1:0];
                                    r_ran    <= n_ran_sum[RAN_W] ? {RAN_W{1'b1}} :
                                                n_ran_sum[RAN_W-1:0];
                                end
                            end
                            OP_BOOST: begin
                                if (r_cur_valid) begin
                                    r_state  <= S_SCAN;
                                    r_insert <= n_contend;
                                    r_ins_id <= r_cur_task;
                                    r_ins_vr <= r_cur_vr;
                                end
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    // read data arrives in the cycle after its address
                    r_pend <= r_issuing;
                    r_pidx <= r_addr;
                    if (r_issuing) begin
                        r_addr <= r_addr + 1'b1;
                        if (r_addr == LAST) begin
                            r_issuing <= 1'b0;
                        end
                    end
                    if (r_pend) begin
                        if (!r_slot_valid[r_pidx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pidx;
                        end
                        if (r_op == OP_DONE && r_slot_valid[r_pidx] &&
                            rd_task == r_id) begin
                            r_slot_valid[r_pidx] <= 1'b0;
                            r_count              <= r_count - 1'b1;
                        end else if (r_slot_valid[r_pidx] &&
                                     (!r_have || rd_vr < r_min)) begin
                            r_have      <= 1'b1;
                            r_min       <= rd_vr;
                            r_best      <= r_pidx;
                            r_best_task <= rd_task;
                        end
                    end
                    if (!r_issuing && !r_pend) begin
                        r_state <= S_FIN;
                    end
                end

                S_MUL: begin
                    if (r_prod > PRW'(r_lat)) begin
                        r_slice <= NUMW'(r_gran);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (div_done) begin
                        r_slice <= div_quo;
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    r_state <= S_PUSH;
                    unique case (r_op)
                        OP_ENQUEUE: begin
                            if (r_insert && !r_free_found) begin
                                r_status <= STAT_FULL;
                            end
                            if (n_ins_ok) begin
                                r_slot_valid[r_free_idx] <= 1'b1;
                                r_count                  <= r_count + 1'b1;
                            end
                            r_floor <= n_new_floor;
                        end
                        OP_PICK: begin
                            r_preempt <= 1'b0;
                            if (r_cur_valid && r_cur_state == TS_BLOCKED) begin
                                r_rel_valid <= 1'b1;
                                r_rel_id    <= r_cur_task;
                                r_rel_vr    <= r_cur_vr;
                            end
                            if (n_keep_prev || r_have) begin
                                if (!n_keep_prev) begin
                                    r_cur_task <= r_best_task;
                                    r_cur_vr   <= r_min;
                                    if (!n_contend) begin
                                        r_slot_valid[r_best] <= 1'b0;
                                        r_count              <= r_count - 1'b1;
                                    end
                                end
                                r_cur_valid <= 1'b1;
                                r_cur_state <= TS_RUNNING;
                                r_ran       <= '0;
                                r_status    <= STAT_PICKED;
                            end else begin
                                r_cur_valid <= 1'b0;
                                r_cur_task  <= '0;
                                r_cur_vr    <= '0;
                                r_cur_state <= TS_BLOCKED;
                                r_status    <= STAT_IDLE;
                            end
                            r_floor <= n_new_floor;
                        end
                        OP_DONE: begin
                            r_floor <= n_new_floor;
                        end
                        OP_BOOST: begin
                            if (r_insert && !r_free_found) begin
                                r_status <= STAT_FULL;
                            end else begin
                                if (n_ins_ok) begin
                                    r_slot_valid[r_free_idx] <= 1'b1;
                                    r_count                  <= r_count + 1'b1;
                                end
                                if (r_cur_state == TS_BLOCKED) begin
                                    r_rel_valid <= 1'b1;
                                    r_rel_id    <= r_cur_task;
                                    r_rel_vr    <= r_cur_vr;
                                end
                                r_preempt   <= 1'b0;
                                r_cur_valid <= 1'b0;
                                r_cur_task  <= '0;
                                r_cur_vr    <= '0;
                                r_cur_state <= TS_BLOCKED;
                                r_floor     <= n_new_floor;
                            end
                        end
                        OP_TICK: begin
                            if (r_ran > RAN_W'(r_slice)) begin
                                r_preempt <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                S_PUSH: begin
                    if (!o_valid || i_ready) begin
                        o_valid             <= 1'b1;
                        o_status            <= r_status;
                        o_task_valid        <= r_cur_valid;
                        o_current_id        <= r_cur_task;
                        o_current_vruntime  <= r_cur_vr;
                        o_released_valid    <= r_rel_valid;
                        o_released_id       <= r_rel_id;
                        o_released_vruntime <= r_rel_vr;
                        o_floor_vruntime    <= r_floor;
                        o_preempt_pending   <= r_preempt;
                        o_queued_count      <= r_count;
                        r_state             <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNTW'($countones(r_slot_valid)))
        else $error("queue count out of step with slot valid bits");

    a_idle_cur_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_valid |-> (r_cur_task == '0 && r_cur_vr == '0))
        else $error("current task fields not cleared while no task runs");

    a_floor_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_floor >= $past(r_floor))
        else $error("vruntime floor went down");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DIV) |-> !o_ready)
        else $error("input taken while an operation is in progress");
`endif

endmodule

`default_nettype wire

// File: sv/fsrq_ram.sv
// ----------------------------------------------------------------------------
// fsrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/fsrq_div.sv
// ----------------------------------------------------------------------------
// fsrq_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsrq_div
    import fsrq_pkg::*;
#(
    parameter int NW = 33,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic      [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   n_sh;
    logic          n_ge;
    logic [DW:0]   n_rem;

    always_comb begin
        n_sh  = {r_rem, r_q[NW-1]};
        n_ge  = (n_sh >= {1'b0, r_den});
        n_rem = n_ge ? (n_sh - {1'b0, r_den}) : n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= {r_q[NW-2:0], n_ge};
                r_rem <= n_rem[DW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_q;

endmodule

`default_nettype wire
